[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on aclk, held off while aresetn is low.
`define PAM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Same, but also checked during reset.
`define PAM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

[rtl/pam_pkg.sv]
// Types, constants and arithmetic helpers for the polynomial core.
package pam_pkg;

    localparam int TERMS     = 32;
    localparam int IDX_W     = $clog2(TERMS);
    localparam int ACT_W     = 3;
    localparam int DEG_IN_W  = 5;
    localparam int DEG_OUT_W = 6;
    localparam int COEF_W    = 32;
    localparam int PROD_W    = 2 * COEF_W;
    localparam int RS_W      = PROD_W - 16;
    localparam int ACC_W     = RS_W + IDX_W;
    localparam int CNT_W     = $clog2(2 * TERMS + 1);
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_A = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ADD_B = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SUM   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DIFF  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PROD  = 3'd5;

    localparam logic signed [PROD_W-1:0] COEF_MAX = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] COEF_MIN = -64'sd2147483648;
    localparam logic signed [PROD_W-1:0] HALF_LSB = 64'sd32768;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic clr_store;
        logic clr_pipe;
        logic pipe_en;
        logic rot_a;
        logic rot_b;
        logic load_a;
        logic load_b;
    } cell_ctrl_t;

    typedef struct packed {
        logic                        vld;
        logic [DEG_OUT_W-1:0]        deg;
        logic signed [COEF_W-1:0]    coef;
    } term_t;

    typedef struct packed {
        logic out_free;
        logic pend_vld;
    } emit_stat_t;

    // clamp to signed 32 bits
    function automatic logic signed [COEF_W-1:0] sat_coef(input logic signed [PROD_W-1:0] v);
        logic signed [COEF_W-1:0] r;
        if (v > COEF_MAX) begin
            r = COEF_MAX[COEF_W-1:0];
        end else if (v < COEF_MIN) begin
            r = COEF_MIN[COEF_W-1:0];
        end else begin
            r = v[COEF_W-1:0];
        end
        return r;
    endfunction

    // Q32.32 -> Q16.16, round half up
    function automatic logic signed [RS_W-1:0] rescale(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        r = (p + HALF_LSB) >>> 16;
        return r[RS_W-1:0];
    endfunction

endpackage

[rtl/pam_cell.sv]
// One coefficient cell: A and B entries, one partial product, one accumulator stage.
module pam_cell
    import pam_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [DEG_IN_W-1:0]      cell_idx,
    input  cell_ctrl_t               ctrl,
    input  logic [DEG_IN_W-1:0]      load_deg,
    input  logic signed [COEF_W-1:0] load_coef,
    input  logic signed [COEF_W-1:0] a_prev,
    input  logic signed [COEF_W-1:0] b_prev,
    input  logic signed [COEF_W-1:0] x_in,
    input  logic signed [ACC_W-1:0]  acc_prev,
    output logic signed [COEF_W-1:0] a_q,
    output logic signed [COEF_W-1:0] b_q,
    output logic signed [ACC_W-1:0]  acc_q
);

    logic signed [COEF_W-1:0] a_reg, a_next;
    logic signed [COEF_W-1:0] b_reg, b_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     hit;

    assign hit = (load_deg == cell_idx);

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (ctrl.clr_store) begin
            a_next = '0;
            b_next = '0;
        end else begin
            if (ctrl.load_a && hit) begin
                a_next = sat_coef(PROD_W'(a_reg) + PROD_W'(load_coef));
            end else if (ctrl.rot_a) begin
                a_next = a_prev;
            end
            if (ctrl.load_b && hit) begin
                b_next = sat_coef(PROD_W'(b_reg) + PROD_W'(load_coef));
            end else if (ctrl.rot_b) begin
                b_next = b_prev;
            end
        end
        if (ctrl.clr_pipe) begin
            prod_next = '0;
            acc_next  = '0;
        end else if (ctrl.pipe_en) begin
            prod_next = PROD_W'(a_reg) * PROD_W'(x_in);
            acc_next  = acc_prev + ACC_W'(rescale(prod_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg    <= '0;
            b_reg    <= '0;
            prod_reg <= '0;
            acc_reg  <= '0;
        end else begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    assign a_q   = a_reg;
    assign b_q   = b_reg;
    assign acc_q = acc_reg;

endmodule

[rtl/pam_emit.sv]
// Result staging: holds one nonzero term back to mark the last, plus the output register.
module pam_emit
    import pam_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  term_t               cand,
    input  logic                take,
    input  logic                flush,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tlast,
    output logic [0:0]          m_tuser,
    output emit_stat_t          stat
);

    logic                     pend_vld_reg, pend_vld_next;
    logic [DEG_OUT_W-1:0]     pend_deg_reg, pend_deg_next;
    logic signed [COEF_W-1:0] pend_coef_reg, pend_coef_next;
    logic                     tvalid_reg, tvalid_next;
    logic [DEG_OUT_W-1:0]     odeg_reg, odeg_next;
    logic signed [COEF_W-1:0] ocoef_reg, ocoef_next;
    logic                     olast_reg, olast_next;
    logic                     ozero_reg, ozero_next;
    logic                     out_free;
    logic                     nz;

    assign out_free = !tvalid_reg || m_tready;
    assign nz       = cand.vld && (cand.coef != '0);

    always_comb begin
        pend_vld_next  = pend_vld_reg;
        pend_deg_next  = pend_deg_reg;
        pend_coef_next = pend_coef_reg;
        tvalid_next    = tvalid_reg;
        odeg_next      = odeg_reg;
        ocoef_next     = ocoef_reg;
        olast_next     = olast_reg;
        ozero_next     = ozero_reg;
        if (out_free) begin
            tvalid_next = 1'b0;
        end
        if (take && nz) begin
            if (pend_vld_reg) begin
                tvalid_next = 1'b1;
                odeg_next   = pend_deg_reg;
                ocoef_next  = pend_coef_reg;
                olast_next  = 1'b0;
                ozero_next  = 1'b0;
            end
            pend_vld_next  = 1'b1;
            pend_deg_next  = cand.deg;
            pend_coef_next = cand.coef;
        end
        if (flush) begin
            tvalid_next   = 1'b1;
            olast_next    = 1'b1;
            pend_vld_next = 1'b0;
            if (pend_vld_reg) begin
                odeg_next  = pend_deg_reg;
                ocoef_next = pend_coef_reg;
                ozero_next = 1'b0;
            end else begin
                odeg_next  = '0;
                ocoef_next = '0;
                ozero_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            tvalid_reg   <= 1'b0;
        end else begin
            pend_vld_reg <= pend_vld_next;
            tvalid_reg   <= tvalid_next;
        end
        pend_deg_reg  <= pend_deg_next;
        pend_coef_reg <= pend_coef_next;
        odeg_reg      <= odeg_next;
        ocoef_reg     <= ocoef_next;
        olast_reg     <= olast_next;
        ozero_reg     <= ozero_next;
    end

    assign m_tvalid      = tvalid_reg;
    assign m_tdata       = {(M_DATA_W - COEF_W - DEG_OUT_W)'(0), ocoef_reg, odeg_reg};
    assign m_tlast       = olast_reg;
    assign m_tuser       = ozero_reg;
    assign stat.out_free = out_free;
    assign stat.pend_vld = pend_vld_reg;

endmodule

[rtl/polynomial_add_sub_multiply_core.sv]
// Load and clear requests finish when accepted; sum/difference and product requests walk the cell chain.
// A flush cycle follows each walk to mark the final term (or emit the zero item).
// One request is taken at a time; a product request (accept, walk steps, flush) takes
// longest, as the 32-cell accumulate chain drains 63 output degrees. Output stalls stretch it.
// Reset (aresetn low, synchronous) clears both coefficient stores and all control state.
`include "assert_macros.svh"

module polynomial_add_sub_multiply_core
    import pam_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [4:0] term_degree, [36:5] term_coef, rest zero
    input  logic [ACT_W-1:0]    s_tuser,   // [2:0] action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [5:0] result_degree, [37:6] result_coef, rest 0
    output logic                m_tlast,
    output logic [0:0]          m_tuser    // [0] is_zero
);

    state_t                   state_reg, state_next;
    logic [ACT_W-1:0]         mode_reg, mode_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    cell_ctrl_t               ctrl;
    term_t                    cand;
    emit_stat_t               estat;
    logic                     take;
    logic                     flush;
    logic                     accept;
    logic                     is_prod;
    logic                     last_step;

    logic [DEG_IN_W-1:0]      load_deg;
    logic signed [COEF_W-1:0] load_coef;
    logic signed [COEF_W-1:0] x_bcast;
    logic signed [COEF_W-1:0] a_q   [TERMS];
    logic signed [COEF_W-1:0] b_q   [TERMS];
    logic signed [ACC_W-1:0]  acc_q [TERMS];

    assign load_deg  = s_tdata[DEG_IN_W-1:0];
    assign load_coef = s_tdata[DEG_IN_W +: COEF_W];
    assign accept    = s_tvalid && s_tready;
    assign is_prod   = (mode_reg == ACT_PROD);

    // B leaves the top cell and is broadcast while the chain rotates; zeros after that.
    assign x_bcast = (cnt_reg < CNT_W'(TERMS)) ? b_q[TERMS-1] : '0;

    // cell p holds degree p; accumulators run from cell 0 up to the top cell
    for (genvar p = 0; p < TERMS; p++) begin : g_cell
        pam_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (DEG_IN_W'(p)),
            .ctrl      (ctrl),
            .load_deg  (load_deg),
            .load_coef (load_coef),
            .a_prev    (a_q[(p + TERMS - 1) % TERMS]),
            .b_prev    (b_q[(p + TERMS - 1) % TERMS]),
            .x_in      (x_bcast),
            .acc_prev  ((p == 0) ? ACC_W'(0) : acc_q[(p + TERMS - 1) % TERMS]),
            .a_q       (a_q[p]),
            .b_q       (b_q[p]),
            .acc_q     (acc_q[p])
        );
    end

    // Candidate term for this walk step. Product terms trail the feed through the product and accumulator registers.
    always_comb begin
        cand = '0;
        if (is_prod) begin
            cand.vld  = (cnt_reg >= CNT_W'(2));
            cand.deg  = DEG_OUT_W'(CNT_W'(2 * TERMS) - cnt_reg);
            cand.coef = sat_coef(PROD_W'(acc_q[TERMS-1]));
        end else begin
            cand.vld  = 1'b1;
            cand.deg  = DEG_OUT_W'(CNT_W'(TERMS - 1) - cnt_reg);
            if (mode_reg == ACT_DIFF) begin
                cand.coef = sat_coef(PROD_W'(a_q[TERMS-1]) - PROD_W'(b_q[TERMS-1]));
            end else begin
                cand.coef = sat_coef(PROD_W'(a_q[TERMS-1]) + PROD_W'(b_q[TERMS-1]));
            end
        end
    end

    assign last_step = is_prod ? (cnt_reg == CNT_W'(2 * TERMS))
                               : (cnt_reg == CNT_W'(TERMS - 1));

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        take       = 1'b0;
        flush      = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    case (s_tuser)
                        ACT_CLEAR: ctrl.clr_store = 1'b1;
                        ACT_ADD_A: ctrl.load_a    = 1'b1;
                        ACT_ADD_B: ctrl.load_b    = 1'b1;
                        ACT_SUM, ACT_DIFF, ACT_PROD: begin
                            mode_next     = s_tuser;
                            cnt_next      = '0;
                            ctrl.clr_pipe = 1'b1;
                            state_next    = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                // one walk step whenever the output side can absorb a term
                if (estat.out_free) begin
                    take = 1'b1;
                    if (is_prod) begin
                        ctrl.pipe_en = 1'b1;
                        ctrl.rot_b   = (cnt_reg < CNT_W'(TERMS));
                    end else begin
                        ctrl.rot_a = 1'b1;
                        ctrl.rot_b = 1'b1;
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (last_step) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (estat.out_free) begin
                    flush      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= ACT_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
        end
    end

    pam_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cand     (cand),
        .take     (take),
        .flush    (flush),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .stat     (estat)
    );

    // a zero-result item is the whole answer: last set, degree and coefficient zero
    `PAM_ASSERT(a_zero_item, m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0), "zero item malformed")
    // the flush always presents a final item
    `PAM_ASSERT(a_flush_last, (state_reg == ST_FLUSH) && estat.out_free |=> m_tvalid && m_tlast, "flush lost last")
    // no held-back term survives into idle
    `PAM_ASSERT(a_idle_clean, (state_reg == ST_IDLE) |-> !estat.pend_vld, "pending term left over")
    // walk counter never runs past the product length (one past the last step while flushing)
    `PAM_ASSERT(a_cnt_range, cnt_reg <= CNT_W'(2 * TERMS + 1), "walk counter overrun")

endmodule

[tb/polynomial_add_sub_multiply_core_checker.sv]
// Result checker for the polynomial core: predicts A+B, A-B and A*B terms.
`timescale 1ns / 100ps

module polynomial_add_sub_multiply_core_checker
    import pam_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [ACT_W-1:0]    s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tlast,
    input  logic [0:0]          m_tuser,
    output int                  fail_count,
    output int                  pending_terms
);

    typedef struct packed {
        logic [DEG_OUT_W-1:0]     deg;
        logic signed [COEF_W-1:0] coef;
        logic                     last;
        logic                     zero;
    } poly_term_t;

    logic signed [COEF_W-1:0] poly_a [TERMS];
    logic signed [COEF_W-1:0] poly_b [TERMS];
    poly_term_t               term_queue [$];

    function automatic logic signed [COEF_W-1:0] clamp64(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[COEF_W-1:0];
    endfunction

    // Q32.32 to Q16.16, nearest with ties up (arithmetic shift floors)
    function automatic longint to_q16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    task automatic predict_request(input logic [ACT_W-1:0] act, input logic [4:0] deg,
                                   input logic signed [COEF_W-1:0] coef);
        logic signed [COEF_W-1:0] res [2*TERMS];
        int top;
        int n;
        longint acc;
        n = 0;
        case (act)
            ACT_CLEAR: begin
                foreach (poly_a[i]) begin
                    poly_a[i] = '0;
                    poly_b[i] = '0;
                end
            end
            ACT_ADD_A: poly_a[deg] = clamp64(longint'(poly_a[deg]) + longint'(coef));
            ACT_ADD_B: poly_b[deg] = clamp64(longint'(poly_b[deg]) + longint'(coef));
            ACT_SUM, ACT_DIFF, ACT_PROD: begin
                if (act == ACT_PROD) begin
                    top = 2 * (TERMS - 1);
                    for (int k = 0; k <= top; k++) begin
                        acc = 0;
                        for (int i = 0; i < TERMS; i++)
                            if (k - i >= 0 && k - i < TERMS)
                                acc += to_q16(longint'(poly_a[i]) * longint'(poly_b[k-i]));
                        res[k] = clamp64(acc);
                    end
                end else begin
                    top = TERMS - 1;
                    for (int k = 0; k <= top; k++)
                        res[k] = clamp64(act == ACT_SUM
                                         ? longint'(poly_a[k]) + longint'(poly_b[k])
                                         : longint'(poly_a[k]) - longint'(poly_b[k]));
                end
                for (int k = top; k >= 0; k--) begin
                    if (res[k] != 0) begin
                        term_queue.push_back('{deg: DEG_OUT_W'(k), coef: res[k],
                                               last: 1'b0, zero: 1'b0});
                        n++;
                    end
                end
                if (n == 0)
                    term_queue.push_back('{deg: '0, coef: '0, last: 1'b1, zero: 1'b1});
                else
                    term_queue[$].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    initial begin
        fail_count    = 0;
        pending_terms = 0;
        foreach (poly_a[i]) begin
            poly_a[i] = '0;
            poly_b[i] = '0;
        end
    end

    always @(posedge aclk) begin
        poly_term_t want;
        poly_term_t got;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{deg: m_tdata[5:0], coef: m_tdata[37:6], last: m_tlast, zero: m_tuser[0]};
                if (term_queue.size() == 0) begin
                    $display("%0t: unexpected term, expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = term_queue.pop_front();
                    if (got.deg != want.deg) begin
                        $display("%0t: degree expected %0d actual %0d", $time, want.deg, got.deg);
                        fail_count++;
                    end
                    if (got.coef != want.coef) begin
                        $display("%0t: coef expected %h actual %h", $time, want.coef, got.coef);
                        fail_count++;
                    end
                    if (got.last != want.last) begin
                        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                        fail_count++;
                    end
                    if (got.zero != want.zero) begin
                        $display("%0t: is_zero expected %b actual %b", $time, want.zero,
                                 got.zero);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_request(s_tuser, s_tdata[4:0], s_tdata[36:5]);
        end
        pending_terms = term_queue.size();
    end

endmodule

[tb/polynomial_add_sub_multiply_core_test.sv]
// Testbench top: drives requests into the polynomial core and gives the verdict.
`timescale 1ns / 100ps

module polynomial_add_sub_multiply_core_test
    import pam_pkg::*;
();

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // [4:0] term_degree, [36:5] term_coef
    logic [ACT_W-1:0]    s_tuser = '0;   // [2:0] action
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // [5:0] result_degree, [37:6] result_coef
    logic                m_tlast;
    logic [0:0]          m_tuser;        // [0] is_zero
    int                  fail_count;
    int                  pending_terms;
    int                  cycle_count = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;

    always #5 aclk = ~aclk;

    polynomial_add_sub_multiply_core DUT (.*);

    polynomial_add_sub_multiply_core_checker checker_i (.*);

    // Receiver backpressure; percentage changes per phase.
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: worst case is products of 63 terms each, every term waiting on an 88% idle
    // receiver; past the limit the run is reported as failed.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("polynomial_add_sub_multiply_core test failed");
            $finish;
        end
    end

    // One request: random idle gap, then hold valid until accepted.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [4:0] deg,
                                input logic [31:0] coef);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b0, coef, deg};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] random_coef();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return {{16{1'($urandom_range(1))}}, 16'($urandom)};   // near zero, both signs
            default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        endcase
    endfunction

    // Mostly a well-formed load/compute sequence; some stray codes and clears.
    task automatic random_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            send_request(($urandom_range(1) != 0) ? ACT_ADD_A : ACT_ADD_B,
                         ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(5)),
                         random_coef());
        else if (pick < 70)
            send_request(ACT_SUM, 5'($urandom), $urandom);
        else if (pick < 80)
            send_request(ACT_DIFF, 5'($urandom), $urandom);
        else if (pick < 88)
            send_request(ACT_PROD, 5'($urandom), $urandom);
        else if (pick < 94)
            send_request(ACT_CLEAR, 5'($urandom), $urandom);
        else
            send_request(3'($urandom_range(7, 6)), 5'($urandom), $urandom);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty results, extremes, saturation, every action.
        send_request(ACT_SUM, 5'd0, 32'd0);
        send_request(ACT_PROD, 5'd0, 32'd0);
        send_request(ACT_ADD_A, 5'd31, 32'h7FFF_FFFF);
        send_request(ACT_ADD_A, 5'd31, 32'h7FFF_FFFF);      // saturates high on load
        send_request(ACT_ADD_B, 5'd31, 32'h8000_0000);
        send_request(ACT_ADD_B, 5'd0, 32'hFFFF_FFFF);
        send_request(ACT_ADD_A, 5'd0, 32'h0001_0000);
        send_request(ACT_SUM, 5'd0, 32'd0);
        send_request(ACT_DIFF, 5'd0, 32'd0);                 // saturating difference
        send_request(ACT_PROD, 5'd0, 32'd0);                 // degree 62, saturated product
        send_request(3'd6, 5'd3, 32'hFFFF_FFFF);
        send_request(3'd7, 5'd3, 32'hFFFF_FFFF);
        send_request(ACT_CLEAR, 5'd0, 32'd0);
        send_request(ACT_ADD_A, 5'd1, 32'h0000_8000);        // 0.5 * -0.5, exact product -0.25
        send_request(ACT_ADD_B, 5'd1, 32'hFFFF_8000);
        send_request(ACT_ADD_A, 5'd2, 32'h0000_0001);
        send_request(ACT_ADD_B, 5'd2, 32'h0000_0001);        // product rounds to zero
        send_request(ACT_PROD, 5'd0, 32'd0);
        send_request(ACT_ADD_A, 5'd1, 32'hFFFF_8000);        // A cancels to zero
        send_request(ACT_DIFF, 5'd0, 32'd0);
        send_request(ACT_CLEAR, 5'd0, 32'd0);
        send_request(ACT_DIFF, 5'd0, 32'd0);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 28 : 0;
            repeat (150) random_request();
        end
        send_request(ACT_PROD, 5'd0, 32'd0);
        s_tvalid <= 1'b0;
        recv_idle_pct = 0;
        @(posedge aclk);

        while (pending_terms != 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
        if (fail_count == 0)
            $display("polynomial_add_sub_multiply_core test passed");
        else
            $display("polynomial_add_sub_multiply_core test failed");
        $finish;
    end

endmodule
